### design/cwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwt_pkg
// Shared types, codes and helper functions of the caller whitelist table.
// ----------------------------------------------------------------------------
package cwt_pkg;

    localparam int NUM_W            = 40;
    localparam int NIB_COUNT        = NUM_W / 4;
    localparam int SLOT_W           = 3;
    localparam int SLOT_COUNT_DEF   = 5;
    localparam int DIGIT_COUNT_DEF  = 10;
    localparam logic [7:0] PREFIX_RESET = 8'h69;
    localparam logic [3:0] DIGIT_MAX    = 4'd9;
    localparam logic [SLOT_W-1:0] NO_SLOT = 3'd7;

    typedef logic [NUM_W-1:0]  num_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef enum logic [2:0] {
        OP_LOOKUP    = 3'd0,
        OP_ADD       = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_SET_ADMIN = 3'd3,
        OP_SET_LAST  = 3'd4,
        OP_CLEAR_ALL = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_INVALID    = 3'd1,
        ST_DUPLICATE  = 3'd2,
        ST_FULL       = 3'd3,
        ST_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_REPORT
    } state_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_WRITE_SLOT,
        CMD_CLEAR_SLOT,
        CMD_SET_ADMIN,
        CMD_SET_LAST,
        CMD_CLEAR_ALL
    } cmd_kind_t;

    // accumulated outcome of one walk over slots, admin and last operator
    typedef struct packed {
        slot_t hit_slot;
        logic  dup_hit;
        slot_t free_slot;
        logic  admin_hit;
        logic  lastop_hit;
    } scan_t;

    // update request from the sequencer to the state store
    typedef struct packed {
        cmd_kind_t kind;
        slot_t     slot;
        logic      restore_last;
    } cmd_t;

    function automatic num_t num_mask(input int digit_count);
        num_t m;
        m = '0;
        for (int b = 0; b < NUM_W; b++)
        begin
            if (b < 4 * digit_count)
                m[b] = 1'b1;
        end
        return m;
    endfunction

    // prefix match on the first two digits and every nibble a decimal digit
    function automatic logic number_valid(input num_t value, input logic [7:0] prefix,
                                          input int digit_count);
        logic [3:0] first;
        logic [3:0] second;
        logic       all_dec;
        first   = '0;
        second  = '0;
        all_dec = 1'b1;
        for (int p = 0; p < NIB_COUNT; p++)
        begin
            if (value[4*p +: 4] > DIGIT_MAX)
                all_dec = 1'b0;
            if (p == digit_count - 1)
                first = value[4*p +: 4];
            if (p == digit_count - 2)
                second = value[4*p +: 4];
        end
        return all_dec && (first == prefix[7:4]) && (second == prefix[3:0]);
    endfunction

endpackage
`default_nettype wire

### design/cwt_match_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwt_match_unit
// Shared 40-bit equality compare, one table entry per cycle while step_en is
// high, with the accumulators for lowest match, second match, highest free
// slot and the admin and last-operator hits.
// ----------------------------------------------------------------------------
module cwt_match_unit #(
    parameter int SLOT_COUNT = cwt_pkg::SLOT_COUNT_DEF,
    parameter int STEP_W     = $clog2(SLOT_COUNT + 2)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  wire                 step_en,
    input  wire [STEP_W-1:0]    step,
    input  cwt_pkg::num_t       n,
    input  cwt_pkg::num_t       operand,
    input  wire                 operand_valid,
    output cwt_pkg::scan_t      result
);

    cwt_pkg::scan_t acc_reg;
    cwt_pkg::scan_t acc_next;
    logic           eq;

    assign eq     = (operand == n);
    assign result = acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (start)
        begin
            acc_next.hit_slot   = cwt_pkg::NO_SLOT;
            acc_next.dup_hit    = 1'b0;
            acc_next.free_slot  = cwt_pkg::NO_SLOT;
            acc_next.admin_hit  = 1'b0;
            acc_next.lastop_hit = 1'b0;
        end
        else if (step_en)
        begin
            if (step < STEP_W'(SLOT_COUNT))
            begin
                if (operand_valid && eq)
                begin
                    if (acc_reg.hit_slot == cwt_pkg::NO_SLOT)
                        acc_next.hit_slot = cwt_pkg::SLOT_W'(step);
                    else
                        acc_next.dup_hit = 1'b1;
                end
                // ascending walk, so the last free one seen is the highest
                if (!operand_valid)
                    acc_next.free_slot = cwt_pkg::SLOT_W'(step);
            end
            else if (step == STEP_W'(SLOT_COUNT))
            begin
                acc_next.admin_hit = operand_valid && eq;
            end
            else
            begin
                acc_next.lastop_hit = eq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg.hit_slot   <= cwt_pkg::NO_SLOT;
            acc_reg.dup_hit    <= 1'b0;
            acc_reg.free_slot  <= cwt_pkg::NO_SLOT;
            acc_reg.admin_hit  <= 1'b0;
            acc_reg.lastop_hit <= 1'b0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule
`default_nettype wire

### design/cwt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cwt_store
// Admin, last-operator and slot registers, the operand select for the shared
// compare and the update port driven by the sequencer.
// ----------------------------------------------------------------------------
module cwt_store #(
    parameter int SLOT_COUNT = cwt_pkg::SLOT_COUNT_DEF,
    parameter int STEP_W     = $clog2(SLOT_COUNT + 2)
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire [STEP_W-1:0]    step,
    input  cwt_pkg::num_t       n,
    input  cwt_pkg::cmd_t       cmd,
    output cwt_pkg::num_t       operand,
    output logic                operand_valid,
    output cwt_pkg::num_t       admin_digits,
    output logic                admin_present,
    output cwt_pkg::num_t       last_operator_digits
);

    cwt_pkg::num_t admin_reg;
    cwt_pkg::num_t admin_next;
    logic          present_reg;
    logic          present_next;
    cwt_pkg::num_t last_reg;
    cwt_pkg::num_t last_next;
    cwt_pkg::num_t slot_digits_reg [SLOT_COUNT];
    cwt_pkg::num_t slot_digits_next [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] slot_valid_reg;
    logic [SLOT_COUNT-1:0] slot_valid_next;

    assign admin_digits         = admin_reg;
    assign admin_present        = present_reg;
    assign last_operator_digits = last_reg;

    // walk order: slots, then admin, then last operator
    always_comb
    begin
        operand       = last_reg;
        operand_valid = 1'b1;
        if (step == STEP_W'(SLOT_COUNT))
        begin
            operand       = admin_reg;
            operand_valid = present_reg;
        end
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (step == STEP_W'(i))
            begin
                operand       = slot_digits_reg[i];
                operand_valid = slot_valid_reg[i];
            end
        end
    end

    always_comb
    begin
        admin_next       = admin_reg;
        present_next     = present_reg;
        last_next        = last_reg;
        slot_digits_next = slot_digits_reg;
        slot_valid_next  = slot_valid_reg;
        case (cmd.kind)
            cwt_pkg::CMD_WRITE_SLOT:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (cmd.slot == cwt_pkg::SLOT_W'(i))
                    begin
                        slot_digits_next[i] = n;
                        slot_valid_next[i]  = 1'b1;
                    end
                end
            end
            cwt_pkg::CMD_CLEAR_SLOT:
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    if (cmd.slot == cwt_pkg::SLOT_W'(i))
                    begin
                        slot_digits_next[i] = '0;
                        slot_valid_next[i]  = 1'b0;
                    end
                end
                if (cmd.restore_last)
                    last_next = admin_reg;
            end
            cwt_pkg::CMD_SET_ADMIN:
            begin
                admin_next   = n;
                present_next = 1'b1;
            end
            cwt_pkg::CMD_SET_LAST:
            begin
                last_next = n;
            end
            cwt_pkg::CMD_CLEAR_ALL:
            begin
                admin_next   = '0;
                present_next = 1'b0;
                last_next    = '0;
                for (int i = 0; i < SLOT_COUNT; i++)
                    slot_digits_next[i] = '0;
                slot_valid_next = '0;
            end
            default:
            begin
                admin_next = admin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            admin_reg      <= '0;
            present_reg    <= 1'b0;
            last_reg       <= '0;
            slot_valid_reg <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
                slot_digits_reg[i] <= '0;
        end
        else
        begin
            admin_reg       <= admin_next;
            present_reg     <= present_next;
            last_reg        <= last_next;
            slot_valid_reg  <= slot_valid_next;
            slot_digits_reg <= slot_digits_next;
        end
    end

endmodule
`default_nettype wire

### design/caller_whitelist_table_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caller_whitelist_table_top
// Table of authorized caller numbers: admin, last operator and a row of slots.
// ----------------------------------------------------------------------------
// Usage:
//   A request (operation, number) is taken when in_valid is high and in_stall
//   is low. in_stall stays high while a request is being worked on, so one
//   request is in the block at a time.
//   Each request walks the slots, the admin and the last operator through one
//   shared 40-bit comparator, one entry per cycle, then updates the table and
//   forms the result in the apply state and loads the output register in the
//   report state. A new request is taken only after the previous one has
//   left the report state.
//   The result sits in an output register, held while out_stall is high; the
//   next request is still taken and worked on, and waits for that register
//   only in the report state.
//   valid_prefix is written on the cfg channel (cfg_valid, cfg_ready always
//   high); the user must write it only while the block is idle, as the block
//   itself has no check for this.
//   Reset clears the table, the admin and last operator, drops out_valid and
//   loads valid_prefix with 0x69.
// ----------------------------------------------------------------------------
module caller_whitelist_table_top #(
    parameter int SLOT_COUNT  = cwt_pkg::SLOT_COUNT_DEF,
    parameter int DIGIT_COUNT = cwt_pkg::DIGIT_COUNT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire [7:0]   cfg_data,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [2:0]   operation,
    input  wire [39:0]  number,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [2:0]  status,
    output logic        registered,
    output logic        is_admin,
    output logic [2:0]  slot_index,
    output logic [39:0] report_number,
    output logic        admin_known
);

    localparam int STEP_W = $clog2(SLOT_COUNT + 2);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SLOT_COUNT + 1);
    localparam cwt_pkg::num_t NUM_MASK = cwt_pkg::num_mask(DIGIT_COUNT);

    cwt_pkg::state_t   state_reg;
    cwt_pkg::state_t   state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [7:0]        prefix_reg;
    cwt_pkg::op_t      op_reg;
    cwt_pkg::num_t     n_reg;

    cwt_pkg::status_t  res_status_reg;
    cwt_pkg::status_t  res_status_next;
    cwt_pkg::slot_t    res_slot_reg;
    cwt_pkg::slot_t    res_slot_next;
    logic              res_reg_reg;
    logic              res_reg_next;
    logic              res_adm_reg;
    logic              res_adm_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [2:0]        status_reg;
    logic              registered_reg;
    logic              is_admin_reg;
    logic [2:0]        slot_index_reg;
    cwt_pkg::num_t     report_reg;
    logic              admin_known_reg;

    logic              accept;
    logic              scan_en;
    logic              out_load;
    logic              n_valid;
    logic              last_valid;
    logic              slot_hit;
    cwt_pkg::scan_t    scan;
    cwt_pkg::cmd_t     cmd;
    cwt_pkg::num_t     operand;
    logic              operand_valid;
    cwt_pkg::num_t     admin_digits;
    logic              admin_present;
    cwt_pkg::num_t     last_digits;
    cwt_pkg::num_t     report_value;

    assign cfg_ready     = 1'b1;
    assign accept        = in_valid && !in_stall;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign registered    = registered_reg;
    assign is_admin      = is_admin_reg;
    assign slot_index    = slot_index_reg;
    assign report_number = report_reg;
    assign admin_known   = admin_known_reg;

    assign n_valid      = cwt_pkg::number_valid(n_reg, prefix_reg, DIGIT_COUNT);
    assign last_valid   = cwt_pkg::number_valid(last_digits, prefix_reg, DIGIT_COUNT);
    assign report_value = last_valid ? last_digits : admin_digits;
    assign slot_hit     = (scan.hit_slot != cwt_pkg::NO_SLOT);

    cwt_match_unit #(
        .SLOT_COUNT (SLOT_COUNT),
        .STEP_W     (STEP_W)
    ) u_match (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (accept),
        .step_en       (scan_en),
        .step          (step_reg),
        .n             (n_reg),
        .operand       (operand),
        .operand_valid (operand_valid),
        .result        (scan)
    );

    cwt_store #(
        .SLOT_COUNT (SLOT_COUNT),
        .STEP_W     (STEP_W)
    ) u_store (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (step_reg),
        .n                    (n_reg),
        .cmd                  (cmd),
        .operand              (operand),
        .operand_valid        (operand_valid),
        .admin_digits         (admin_digits),
        .admin_present        (admin_present),
        .last_operator_digits (last_digits)
    );

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        in_stall        = (state_reg != cwt_pkg::S_IDLE);
        scan_en         = 1'b0;
        out_load        = 1'b0;
        cmd.kind        = cwt_pkg::CMD_NONE;
        cmd.slot        = scan.hit_slot;
        cmd.restore_last = 1'b0;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_reg_next    = res_reg_reg;
        res_adm_next    = res_adm_reg;
        out_valid_next  = out_valid_reg && out_stall;

        case (state_reg)
            cwt_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cwt_pkg::S_SCAN;
                    step_next  = '0;
                end
            end
            cwt_pkg::S_SCAN:
            begin
                scan_en = 1'b1;
                if (step_reg == LAST_STEP)
                    state_next = cwt_pkg::S_APPLY;
                else
                    step_next = step_reg + 1'b1;
            end
            cwt_pkg::S_APPLY:
            begin
                res_status_next = cwt_pkg::ST_OK;
                res_slot_next   = cwt_pkg::NO_SLOT;
                res_adm_next    = scan.admin_hit;
                res_reg_next    = scan.admin_hit || slot_hit;
                case (op_reg)
                    cwt_pkg::OP_ADD:
                    begin
                        if (!n_valid)
                            res_status_next = cwt_pkg::ST_INVALID;
                        else if (scan.admin_hit || slot_hit)
                        begin
                            res_status_next = cwt_pkg::ST_DUPLICATE;
                            res_slot_next   = scan.hit_slot;
                        end
                        else if (scan.free_slot != cwt_pkg::NO_SLOT)
                        begin
                            cmd.kind      = cwt_pkg::CMD_WRITE_SLOT;
                            cmd.slot      = scan.free_slot;
                            res_slot_next = scan.free_slot;
                            res_reg_next  = 1'b1;
                        end
                        else
                            res_status_next = cwt_pkg::ST_FULL;
                    end
                    cwt_pkg::OP_REMOVE:
                    begin
                        res_slot_next = scan.hit_slot;
                        // only a second copy keeps the number in the slots
                        res_reg_next  = scan.admin_hit || scan.dup_hit;
                        if (!slot_hit)
                            res_status_next = cwt_pkg::ST_NOT_FOUND;
                        else
                        begin
                            cmd.kind         = cwt_pkg::CMD_CLEAR_SLOT;
                            cmd.restore_last = scan.lastop_hit;
                        end
                    end
                    cwt_pkg::OP_SET_ADMIN:
                    begin
                        cmd.kind     = cwt_pkg::CMD_SET_ADMIN;
                        res_adm_next = 1'b1;
                        res_reg_next = 1'b1;
                    end
                    cwt_pkg::OP_SET_LAST:
                    begin
                        cmd.kind = cwt_pkg::CMD_SET_LAST;
                    end
                    cwt_pkg::OP_CLEAR_ALL:
                    begin
                        cmd.kind     = cwt_pkg::CMD_CLEAR_ALL;
                        res_adm_next = 1'b0;
                        res_reg_next = 1'b0;
                    end
                    default:
                    begin
                        // lookup, and the unused codes behave the same
                        res_slot_next = scan.hit_slot;
                        if (!(scan.admin_hit || slot_hit))
                            res_status_next = cwt_pkg::ST_NOT_FOUND;
                    end
                endcase
                state_next = cwt_pkg::S_REPORT;
            end
            cwt_pkg::S_REPORT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = cwt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cwt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwt_pkg::S_IDLE;
            step_reg      <= '0;
            prefix_reg    <= cwt_pkg::PREFIX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                prefix_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= cwt_pkg::op_t'(operation);
            n_reg  <= number & NUM_MASK;
        end
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_reg_reg    <= res_reg_next;
        res_adm_reg    <= res_adm_next;
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            registered_reg  <= res_reg_reg;
            is_admin_reg    <= res_adm_reg;
            slot_index_reg  <= res_slot_reg;
            report_reg      <= report_value;
            admin_known_reg <= admin_present;
        end
    end

    // rejected or missing numbers never name a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == cwt_pkg::ST_INVALID || status == cwt_pkg::ST_FULL
                      || status == cwt_pkg::ST_NOT_FOUND)
        |-> slot_index == cwt_pkg::NO_SLOT)
        else $error("failed status carries a slot index");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_admin |-> registered && admin_known)
        else $error("admin match without registered or admin_known");

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == cwt_pkg::S_SCAN && step_reg == '0)
        else $error("accepted request did not start the walk");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cwt_pkg::S_REPORT && (!out_valid_reg || !out_stall)
        |=> out_valid_reg && state_reg == cwt_pkg::S_IDLE)
        else $error("result not delivered to the output register");

endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the caller whitelist table against a mirror of its table, admin and
// last operator. Directed requests cover the corner cases first. Random phases
// follow, each under its own prefix, with random gaps and stalls on both
// channels except in the one steady phase.
// ----------------------------------------------------------------------------

localparam int TABLE_SLOTS  = 5;
localparam int TABLE_DIGITS = 10;

// unused operation codes, handled as a lookup
localparam logic [2:0] OP_SPARE_LO = 3'd6;
localparam logic [2:0] OP_SPARE_HI = 3'd7;

typedef struct packed {
    logic [2:0]     status;
    logic           registered;
    logic           is_admin;
    cwt_pkg::slot_t slot;
    cwt_pkg::num_t  report;
    logic           admin_known;
} caller_result_t;

class table_mirror;
    logic [7:0]     prefix;
    cwt_pkg::num_t  admin_num;
    logic           admin_set;
    cwt_pkg::num_t  last_op;
    cwt_pkg::num_t  slot_num [TABLE_SLOTS];
    logic           slot_used [TABLE_SLOTS];
    caller_result_t pending_results [$];
    int             errors;
    int             requests;
    int             checked;
    int             status_seen [5];

    function new();
        prefix   = cwt_pkg::PREFIX_RESET;
        errors   = 0;
        requests = 0;
        checked  = 0;
        foreach (status_seen[s])
            status_seen[s] = 0;
        wipe();
    endfunction

    function void wipe();
        admin_num = '0;
        admin_set = 1'b0;
        last_op   = '0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            slot_num[i]  = '0;
            slot_used[i] = 1'b0;
        end
    endfunction

    // two prefix digits and decimal digits throughout
    function logic well_formed(cwt_pkg::num_t n);
        logic ok;
        ok = (n[39:36] == prefix[7:4]) && (n[35:32] == prefix[3:0]);
        for (int p = 0; p < TABLE_DIGITS; p++)
        begin
            if (n[4*p +: 4] > cwt_pkg::DIGIT_MAX)
                ok = 1'b0;
        end
        return ok;
    endfunction

    function cwt_pkg::slot_t lowest_hit(cwt_pkg::num_t n);
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            if (slot_used[i] && slot_num[i] == n)
                return cwt_pkg::slot_t'(i);
        end
        return cwt_pkg::NO_SLOT;
    endfunction

    function void take_request(logic [2:0] op, cwt_pkg::num_t n);
        caller_result_t   r;
        logic             adm;
        cwt_pkg::slot_t   hit;
        cwt_pkg::slot_t   slot;
        cwt_pkg::status_t st;
        st   = cwt_pkg::ST_OK;
        slot = cwt_pkg::NO_SLOT;
        requests++;
        case (op)
            cwt_pkg::OP_ADD:
            begin
                adm = admin_set && admin_num == n;
                hit = lowest_hit(n);
                if (!well_formed(n))
                    st = cwt_pkg::ST_INVALID;
                else if (adm || hit != cwt_pkg::NO_SLOT)
                begin
                    st   = cwt_pkg::ST_DUPLICATE;
                    slot = hit;
                end
                else
                begin
                    st = cwt_pkg::ST_FULL;
                    // highest free slot first
                    for (int i = TABLE_SLOTS - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                        begin
                            slot_num[i]  = n;
                            slot_used[i] = 1'b1;
                            slot         = cwt_pkg::slot_t'(i);
                            st           = cwt_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            cwt_pkg::OP_REMOVE:
            begin
                hit  = lowest_hit(n);
                slot = hit;
                if (hit == cwt_pkg::NO_SLOT)
                    st = cwt_pkg::ST_NOT_FOUND;
                else
                begin
                    slot_used[hit] = 1'b0;
                    slot_num[hit]  = '0;
                    if (last_op == n)
                        last_op = admin_num;
                end
            end
            cwt_pkg::OP_SET_ADMIN:
            begin
                admin_num = n;
                admin_set = 1'b1;
            end
            cwt_pkg::OP_SET_LAST:
                last_op = n;
            cwt_pkg::OP_CLEAR_ALL:
                wipe();
            default:
            begin
                hit  = lowest_hit(n);
                slot = hit;
                adm  = admin_set && admin_num == n;
                if (adm || hit != cwt_pkg::NO_SLOT)
                    st = cwt_pkg::ST_OK;
                else
                    st = cwt_pkg::ST_NOT_FOUND;
            end
        endcase

        adm           = admin_set && admin_num == n;
        r.status      = st;
        r.registered  = adm || lowest_hit(n) != cwt_pkg::NO_SLOT;
        r.is_admin    = adm;
        r.slot        = slot;
        r.report      = well_formed(last_op) ? last_op : admin_num;
        r.admin_known = admin_set;
        status_seen[int'(st)]++;
        pending_results.push_back(r);
    endfunction

    task flag_mismatch(string what, logic [39:0] got, logic [39:0] want);
        errors++;
        $display("[%0t] mismatch %0d on %s: got %h, want %h", $time, errors, what, got, want);
    endtask

    task compare_result(caller_result_t got);
        caller_result_t want;
        checked++;
        if (pending_results.size() == 0)
        begin
            flag_mismatch("result with no request waiting", got.report, '0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            flag_mismatch("status", 40'(got.status), 40'(want.status));
        if (got.registered !== want.registered)
            flag_mismatch("registered", 40'(got.registered), 40'(want.registered));
        if (got.is_admin !== want.is_admin)
            flag_mismatch("is_admin", 40'(got.is_admin), 40'(want.is_admin));
        if (got.slot !== want.slot)
            flag_mismatch("slot_index", 40'(got.slot), 40'(want.slot));
        if (got.report !== want.report)
            flag_mismatch("report_number", got.report, want.report);
        if (got.admin_known !== want.admin_known)
            flag_mismatch("admin_known", 40'(got.admin_known), 40'(want.admin_known));
    endtask

    task close_out();
        if (pending_results.size() != 0)
            flag_mismatch("results never arrived", 40'(pending_results.size()), '0);
    endtask
endclass

module tb;

    localparam int IDLE_GUARD  = 12;
    localparam int PHASE_ITEMS = 65;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [39:0] number;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic        registered;
    logic        is_admin;
    logic [2:0]  slot_index;
    logic [39:0] report_number;
    logic        admin_known;

    table_mirror   mirror = new();
    bit            steady;
    int            phases_run;
    cwt_pkg::num_t pool [8];

    caller_whitelist_table_top #(
        .SLOT_COUNT  (TABLE_SLOTS),
        .DIGIT_COUNT (TABLE_DIGITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .number        (number),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .registered    (registered),
        .is_admin      (is_admin),
        .slot_index    (slot_index),
        .report_number (report_number),
        .admin_known   (admin_known)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task send_request(logic [2:0] op, cwt_pkg::num_t n);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        number    <= n;
        do
            @(posedge clk);
        while (in_stall);
        mirror.take_request(op, n);
    endtask

    // hold off requests until every result is back
    task drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (mirror.pending_results.size() != 0)
            @(posedge clk);
    endtask

    task write_prefix(logic [7:0] v);
        drain();
        repeat (IDLE_GUARD) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.prefix = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function cwt_pkg::num_t make_number(logic [7:0] pfx);
        cwt_pkg::num_t n;
        n[39:32] = pfx;
        for (int p = 0; p < 8; p++)
            n[4*p +: 4] = 4'($urandom_range(0, 9));
        return n;
    endfunction

    function cwt_pkg::num_t pick_number(logic [7:0] pfx);
        int            r;
        cwt_pkg::num_t n;
        r = $urandom_range(0, 99);
        n = pool[$urandom_range(0, 7)];
        if (r < 70)
            return n;
        if (r < 80)
            return make_number(pfx);
        if (r < 88)
            return {8'($urandom), 32'($urandom)};
        if (r < 94)
        begin
            // one nibble pushed out of decimal range
            n[4*$urandom_range(0, 9) +: 4] = 4'($urandom_range(10, 15));
            return n;
        end
        n[$urandom_range(32, 39)] = ~n[$urandom_range(32, 39)];
        return n;
    endfunction

    function logic [2:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return cwt_pkg::OP_LOOKUP;
        if (r < 55) return cwt_pkg::OP_ADD;
        if (r < 70) return cwt_pkg::OP_REMOVE;
        if (r < 78) return cwt_pkg::OP_SET_ADMIN;
        if (r < 88) return cwt_pkg::OP_SET_LAST;
        if (r < 91) return cwt_pkg::OP_CLEAR_ALL;
        if (r < 95) return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    task run_phase(logic [7:0] pfx, bit calm);
        write_prefix(pfx);
        steady = calm;
        phases_run++;
        for (int i = 0; i < 8; i++)
            pool[i] = make_number(pfx);
        for (int k = 0; k < PHASE_ITEMS; k++)
        begin
            if (k == PHASE_ITEMS / 2)
                drain();
            send_request(pick_op(), pick_number(pfx));
        end
        steady = 1'b0;
    endtask

    // result side: random stall before each result
    initial
    begin : result_sink
        int             hold;
        caller_result_t got;
        @(negedge clk);
        forever
        begin
            hold = steady ? 0 : $urandom_range(0, 4);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            got = {status, registered, is_admin, slot_index, report_number, admin_known};
            mirror.compare_result(got);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        operation  = cwt_pkg::OP_LOOKUP;
        number     = '0;
        out_stall  = 1'b0;
        steady     = 1'b0;
        phases_run = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_prefix(cwt_pkg::PREFIX_RESET);
        phases_run = 1;
        send_request(cwt_pkg::OP_LOOKUP, 40'h00_0000_0000);
        send_request(cwt_pkg::OP_LOOKUP, 40'hFF_FFFF_FFFF);
        send_request(cwt_pkg::OP_ADD, 40'h69_0000_0000);
        send_request(cwt_pkg::OP_ADD, 40'h69_9999_9999);
        send_request(cwt_pkg::OP_ADD, 40'h69_0000_0000);
        send_request(cwt_pkg::OP_ADD, 40'h69_1234_567A);
        send_request(cwt_pkg::OP_ADD, 40'hF9_1234_5678);
        send_request(cwt_pkg::OP_ADD, 40'h96_1234_5678);
        send_request(cwt_pkg::OP_ADD, 40'h69_1111_1111);
        send_request(cwt_pkg::OP_ADD, 40'h69_2222_2222);
        send_request(cwt_pkg::OP_ADD, 40'h69_3333_3333);
        // table full now
        send_request(cwt_pkg::OP_ADD, 40'h69_4444_4444);
        send_request(cwt_pkg::OP_SET_ADMIN, 40'h69_4444_4444);
        // matches only the admin
        send_request(cwt_pkg::OP_ADD, 40'h69_4444_4444);
        send_request(cwt_pkg::OP_LOOKUP, 40'h69_4444_4444);
        send_request(cwt_pkg::OP_SET_LAST, 40'h69_2222_2222);
        // last operator falls back to the admin
        send_request(cwt_pkg::OP_REMOVE, 40'h69_2222_2222);
        send_request(cwt_pkg::OP_REMOVE, 40'h69_2222_2222);
        // the admin is never removed
        send_request(cwt_pkg::OP_REMOVE, 40'h69_4444_4444);
        send_request(cwt_pkg::OP_ADD, 40'h69_5555_5555);
        send_request(cwt_pkg::OP_SET_LAST, 40'hAB_CDEF_0123);
        send_request(OP_SPARE_LO, 40'h69_9999_9999);
        send_request(OP_SPARE_HI, 40'h69_4444_4444);
        send_request(cwt_pkg::OP_CLEAR_ALL, 40'h00_0000_0000);
        send_request(cwt_pkg::OP_SET_ADMIN, 40'hFF_FFFF_FFFF);
        send_request(cwt_pkg::OP_LOOKUP, 40'hFF_FFFF_FFFF);

        run_phase(8'h00, 1'b0);
        run_phase(8'hFF, 1'b0);
        run_phase(8'h99, 1'b1);
        run_phase(8'h12, 1'b0);
        run_phase({4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))}, 1'b0);
        run_phase(cwt_pkg::PREFIX_RESET, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        mirror.close_out();

        $display("%0d requests over %0d prefix settings, %0d results checked",
                 mirror.requests, phases_run, mirror.checked);
        $display("status counts: ok %0d, invalid %0d, duplicate %0d, full %0d, not found %0d",
                 mirror.status_seen[cwt_pkg::ST_OK], mirror.status_seen[cwt_pkg::ST_INVALID],
                 mirror.status_seen[cwt_pkg::ST_DUPLICATE], mirror.status_seen[cwt_pkg::ST_FULL],
                 mirror.status_seen[cwt_pkg::ST_NOT_FOUND]);
        if (mirror.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### caller_whitelist_table_top.f
design/cwt_pkg.sv
design/cwt_match_unit.sv
design/cwt_store.sv
design/caller_whitelist_table_top.sv
dv/tb.sv
